### sv/circular_deque_top_defines.svh
// circular_deque_top_defines.svh: assertion macros for the deque block
// no dependencies; included by circular_deque_top
`ifndef CIRCULAR_DEQUE_TOP_DEFINES_SVH
`define CIRCULAR_DEQUE_TOP_DEFINES_SVH

`ifndef SYNTH

// property that must hold at every clock edge out of reset
`define CDQ_ASSERT_NOW(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("deque check failed");

// antecedent this cycle implies consequent on the next cycle
`define CDQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("deque check failed");

`else

`define CDQ_ASSERT_NOW(label, clk, rst_n, prop)
`define CDQ_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

### sv/cdq_pkg.sv
// cdq_pkg: request and status codes and the cell control struct
// no dependencies; used by cdq_cell and circular_deque_top
package cdq_pkg;

	typedef enum logic [1:0] {
		MODE_PUSH_FRONT = 2'd0,
		MODE_PUSH_REAR  = 2'd1,
		MODE_POP_FRONT  = 2'd2,
		MODE_POP_REAR   = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	localparam int COUNT_OUT_W = 4;

	// shift and edit commands, at most one high, broadcast to every cell
	typedef struct packed {
		logic push_front;
		logic push_rear;
		logic pop_front;
		logic pop_rear;
	} dq_ctl_t;

endpackage

### sv/cdq_cell.sv
// cdq_cell: one slot of the deque shift row, with its occupied flag
// depends on cdq_pkg
module cdq_cell #(
	parameter int DATA_WIDTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  cdq_pkg::dq_ctl_t       ctl,
	input  logic [DATA_WIDTH-1:0]  push_word,
	input  logic [DATA_WIDTH-1:0]  left_word,
	input  logic                   left_valid,
	input  logic [DATA_WIDTH-1:0]  right_word,
	input  logic                   right_valid,
	output logic [DATA_WIDTH-1:0]  word,
	output logic                   valid,
	output logic                   last
);
	import cdq_pkg::*;

	logic [DATA_WIDTH-1:0] word_q;
	logic                  valid_q;
	logic                  rear_slot;

	// first empty cell takes a rear push
	assign rear_slot = !valid_q && left_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.push_front) begin
			valid_q <= left_valid;
		end else if (ctl.pop_front) begin
			valid_q <= right_valid;
		end else if (ctl.push_rear && rear_slot) begin
			valid_q <= 1'b1;
		end else if (ctl.pop_rear && last) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.push_front) begin
			word_q <= left_word;
		end else if (ctl.pop_front) begin
			word_q <= right_word;
		end else if (ctl.push_rear && rear_slot) begin
			word_q <= push_word;
		end
	end

	assign word  = word_q;
	assign valid = valid_q;
	assign last  = valid_q && !right_valid;

endmodule

### sv/circular_deque_top.sv
// circular_deque_top: double-ended queue built as a row of shifting cells
// depends on cdq_pkg, cdq_cell and circular_deque_top_defines.svh
//
// Usage: a request (mode, data_in) is transferred at a rising edge with
// start high and busy low. busy stays low, so a request may be issued
// every cycle. Pushes and pops at the front shift the whole cell row by
// one place; a rear push writes the first empty cell, a rear pop clears
// the last occupied one, all in the cycle of the request.
// The result (status, data_out, count_after) appears in the cycle after the
// request for exactly one cycle, marked by done. Throughput 1 request per
// cycle, set by the single update of the cell row.
// A push into a full deque returns status full, a pop from an empty deque
// returns status empty; neither changes the contents. data_out is zero
// except for a successful pop.
// The receiver cannot stall; each result is transferred in its done cycle.
// Reset clears all occupied flags and the count: the deque starts empty.
`include "circular_deque_top_defines.svh"

module circular_deque_top #(
	parameter int DEPTH      = 8,
	parameter int DATA_WIDTH = 32
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic [1:0]                           mode,
	input  logic signed [DATA_WIDTH-1:0]         data_in,
	output logic                                 done,
	output logic [1:0]                           status,
	output logic signed [DATA_WIDTH-1:0]         data_out,
	output logic [cdq_pkg::COUNT_OUT_W-1:0]      count_after
);
	import cdq_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);

	logic                  accept;
	logic                  is_push;
	logic                  full;
	logic                  empty;
	dq_ctl_t               ctl;
	logic [CW-1:0]         count_q;
	logic [CW-1:0]         count_next;
	status_t               status_next;
	logic [DATA_WIDTH-1:0] pop_word;
	logic [DATA_WIDTH-1:0] rear_word;

	logic [DATA_WIDTH-1:0] cell_word [DEPTH];
	logic [DEPTH-1:0]      cell_valid;
	logic [DEPTH-1:0]      cell_last;

	logic                  done_q;
	status_t               status_q;
	logic [DATA_WIDTH-1:0] data_out_q;
	logic [CW-1:0]         count_out_q;

	assign busy   = 1'b0;
	assign accept = start && !busy;
	assign is_push = (mode == MODE_PUSH_FRONT) || (mode == MODE_PUSH_REAR);
	assign full   = (count_q == CW'(DEPTH));
	assign empty  = (count_q == '0);

	always_comb begin
		ctl.push_front = accept && (mode == MODE_PUSH_FRONT) && !full;
		ctl.push_rear  = accept && (mode == MODE_PUSH_REAR) && !full;
		ctl.pop_front  = accept && (mode == MODE_POP_FRONT) && !empty;
		ctl.pop_rear   = accept && (mode == MODE_POP_REAR) && !empty;
	end

	genvar i;
	generate
		for (i = 0; i < DEPTH; i++) begin : g_cell
			logic [DATA_WIDTH-1:0] lw;
			logic                  lv;
			logic [DATA_WIDTH-1:0] rw;
			logic                  rv;
			if (i == 0) begin : g_first
				assign lw = data_in;
				assign lv = 1'b1;
			end else begin : g_mid_l
				assign lw = cell_word[i-1];
				assign lv = cell_valid[i-1];
			end
			if (i == DEPTH - 1) begin : g_end
				assign rw = '0;
				assign rv = 1'b0;
			end else begin : g_mid_r
				assign rw = cell_word[i+1];
				assign rv = cell_valid[i+1];
			end
			cdq_cell #(
				.DATA_WIDTH(DATA_WIDTH)
			) u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.ctl        (ctl),
				.push_word  (data_in),
				.left_word  (lw),
				.left_valid (lv),
				.right_word (rw),
				.right_valid(rv),
				.word       (cell_word[i]),
				.valid      (cell_valid[i]),
				.last       (cell_last[i])
			);
		end
	endgenerate

	// and-or select of the last occupied cell
	always_comb begin
		rear_word = '0;
		for (int k = 0; k < DEPTH; k++) begin
			rear_word = rear_word | (cell_word[k] & {DATA_WIDTH{cell_last[k]}});
		end
	end

	always_comb begin
		count_next  = count_q;
		status_next = ST_DONE;
		pop_word    = '0;
		if (is_push) begin
			if (full) begin
				status_next = ST_FULL;
			end else begin
				count_next = count_q + CW'(1);
			end
		end else begin
			if (empty) begin
				status_next = ST_EMPTY;
			end else begin
				count_next = count_q - CW'(1);
				pop_word   = (mode == MODE_POP_FRONT) ? cell_word[0] : rear_word;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= accept;
			if (accept) begin
				count_q <= count_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q    <= status_next;
			data_out_q  <= pop_word;
			count_out_q <= count_next;
		end
	end

	assign done        = done_q;
	assign status      = status_q;
	assign data_out    = data_out_q;
	assign count_after = COUNT_OUT_W'(count_out_q);

	`CDQ_ASSERT_NEXT(a_result_follows, clk, arst_n, accept, done)
	`CDQ_ASSERT_NEXT(a_no_spurious_result, clk, arst_n, !accept, !done)
	`CDQ_ASSERT_NOW(a_count_matches_cells, clk, arst_n, $countones(cell_valid) == count_q)
	`CDQ_ASSERT_NOW(a_cells_packed, clk, arst_n, (cell_valid & (cell_valid + DEPTH'(1))) == '0)

endmodule

### bench/testbench.sv
`timescale 1ns / 100ps
// testbench: random and directed check of the double-ended queue block
// depends on cdq_pkg and circular_deque_top; a scoreboard tracks the deque contents
module testbench;
	import cdq_pkg::*;

	localparam int DEPTH      = 8;
	localparam int DATA_WIDTH = 32;
	localparam int STALL_LIMIT = 1000;

	typedef logic signed [DATA_WIDTH-1:0] word_t;

	typedef struct {
		status_t                  status;
		word_t                    data;
		logic [COUNT_OUT_W-1:0]   count;
	} deque_result_t;

	class deque_scoreboard;
		word_t          slot_mem [DEPTH];
		int unsigned    front_idx;
		int unsigned    rear_idx;
		int unsigned    occupancy;
		int             err_count;
		deque_result_t  expected_q [$];

		function new();
			front_idx = 0;
			rear_idx  = 0;
			occupancy = 0;
			err_count = 0;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		task report(input string msg);
			$display("%0t MISMATCH: %s", $time, msg);
			err_count++;
		endtask

		function void note_request(input mode_t req, input word_t word);
			deque_result_t r;
			r.status = ST_DONE;
			r.data   = '0;
			if (req == MODE_PUSH_FRONT || req == MODE_PUSH_REAR) begin
				if (occupancy >= DEPTH) begin
					r.status = ST_FULL;
				end else begin
					if (occupancy == 0) begin
						front_idx = 0;
						rear_idx  = 0;
						slot_mem[0] = word;
					end else if (req == MODE_PUSH_FRONT) begin
						front_idx = (front_idx == 0) ? DEPTH - 1 : front_idx - 1;
						slot_mem[front_idx] = word;
					end else begin
						rear_idx = (rear_idx + 1) % DEPTH;
						slot_mem[rear_idx] = word;
					end
					occupancy++;
				end
			end else if (occupancy == 0) begin
				r.status = ST_EMPTY;
			end else begin
				if (req == MODE_POP_FRONT) begin
					r.data = slot_mem[front_idx];
					front_idx = (front_idx + 1) % DEPTH;
				end else begin
					r.data = slot_mem[rear_idx];
					rear_idx = (rear_idx == 0) ? DEPTH - 1 : rear_idx - 1;
				end
				occupancy--;
				if (occupancy == 0) begin
					front_idx = 0;
					rear_idx  = 0;
				end
			end
			r.count = COUNT_OUT_W'(occupancy);
			expected_q.push_back(r);
		endfunction

		task check_result(input logic [1:0] got_status, input word_t got_data,
				input logic [COUNT_OUT_W-1:0] got_count);
			deque_result_t exp_r;
			if (expected_q.size() == 0) begin
				report("result with no request outstanding");
			end else begin
				exp_r = expected_q.pop_front();
				if (got_status !== exp_r.status)
					report($sformatf("status got %0d exp %0d", got_status, exp_r.status));
				if (got_data !== exp_r.data)
					report($sformatf("data_out got %h exp %h", got_data, exp_r.data));
				if (got_count !== exp_r.count)
					report($sformatf("count_after got %0d exp %0d", got_count, exp_r.count));
			end
		endtask
	endclass

	logic                          clk;
	logic                          arst_n;
	logic                          start;
	logic                          busy;
	logic [1:0]                    mode;
	word_t                         data_in;
	logic                          done;
	logic [1:0]                    status;
	word_t                         data_out;
	logic [COUNT_OUT_W-1:0]        count_after;

	deque_scoreboard sb;
	int stall_cycles;

	circular_deque_top #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.mode        (mode),
		.data_in     (data_in),
		.done        (done),
		.status      (status),
		.data_out    (data_out),
		.count_after (count_after)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_result(status, data_out, count_after);
	end

	always @(posedge clk) begin
		if ((start && !busy) || done) begin
			stall_cycles = 0;
		end else begin
			stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	function automatic word_t pick_word();
		case ($urandom_range(0, 9))
			0:       return {1'b1, {(DATA_WIDTH-1){1'b0}}};
			1:       return {1'b0, {(DATA_WIDTH-1){1'b1}}};
			2:       return '0;
			3:       return '1;
			default: return word_t'($urandom);
		endcase
	endfunction

	// one transfer, then an optional sender gap
	task automatic issue(input mode_t req, input word_t word, input int idle_pct);
		int gap;
		start   <= 1'b1;
		mode    <= req;
		data_in <= word;
		do @(posedge clk); while (busy);
		sb.note_request(req, word);
		if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
			gap = $urandom_range(1, 5);
			start   <= 1'b0;
			mode    <= mode_t'($urandom_range(0, 3));
			data_in <= word_t'($urandom);
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain();
		start <= 1'b0;
		while (sb.pending() > 0) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic run_directed();
		int i;
		issue(MODE_POP_FRONT, pick_word(), 0);
		issue(MODE_POP_REAR, pick_word(), 0);
		issue(MODE_PUSH_FRONT, {1'b0, {(DATA_WIDTH-1){1'b1}}}, 0);
		issue(MODE_POP_REAR, '0, 0);
		issue(MODE_PUSH_REAR, {1'b1, {(DATA_WIDTH-1){1'b0}}}, 0);
		issue(MODE_POP_FRONT, '0, 0);
		for (i = 0; i < DEPTH; i++)
			issue(i[0] ? MODE_PUSH_FRONT : MODE_PUSH_REAR, pick_word(), 0);
		issue(MODE_PUSH_FRONT, '1, 0);
		issue(MODE_PUSH_REAR, '1, 0);
		for (i = 0; i < DEPTH; i++)
			issue(i[0] ? MODE_POP_REAR : MODE_POP_FRONT, pick_word(), 0);
		issue(MODE_POP_REAR, '0, 0);
		issue(MODE_PUSH_REAR, word_t'($urandom), 0);
		issue(MODE_POP_FRONT, '0, 0);
	endtask

	// random walk in segments that lean toward pushes or pops to hit full and empty
	task automatic run_phase(input int n_items, input int idle_pct, input bit pause_mid);
		int i;
		int seg_left;
		int push_bias;
		mode_t req;
		seg_left  = 0;
		push_bias = 50;
		for (i = 0; i < n_items; i++) begin
			if (seg_left == 0) begin
				seg_left  = $urandom_range(8, 40);
				push_bias = $urandom_range(0, 1) ? 75 : 25;
				if ($urandom_range(0, 9) == 0)
					push_bias = 50;
			end
			seg_left--;
			if ($urandom_range(0, 99) < push_bias)
				req = mode_t'($urandom_range(0, 1));
			else
				req = mode_t'(2 + $urandom_range(0, 1));
			issue(req, pick_word(), idle_pct);
			if (pause_mid && i == n_items / 2)
				drain();
		end
	endtask

	initial begin
		clk          = 1'b0;
		arst_n       = 1'b0;
		start        = 1'b0;
		mode         = MODE_PUSH_FRONT;
		data_in      = '0;
		stall_cycles = 0;
		sb = new();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();
		run_phase(270, 0, 1'b0);
		run_phase(260, 68, 1'b1);
		run_phase(260, 11, 1'b0);
		run_phase(260, 0, 1'b1);

		drain();
		repeat (4) @(posedge clk);
		if (sb.err_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule
